[hdl/stc_pkg.sv]
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types, constants and calendar helpers for the seconds to calendar
// date converter.
// ----------------------------------------------------------------------------
package stc_pkg;

    localparam int SecsW  = 32;
    localparam int RemW   = 17;
    localparam int DaysW  = 16;
    localparam int YearW  = 12;

    // shared multiplier operand widths
    localparam int MulAW  = 25;
    localparam int MulBW  = 26;
    localparam int MulPW  = MulAW + MulBW;

    localparam logic [RemW-1:0]  SecsPerDay  = 17'd86400;
    localparam logic [RemW-1:0]  SecsPerHour = 17'd3600;
    localparam logic [RemW-1:0]  SecsPerMin  = 17'd60;
    localparam logic [RemW-1:0]  DaysPerWeek = 17'd7;

    // Reciprocal division: quot = ((numer >> Pre) * Magic) >> Post, exact over
    // the operand range of each division. The pre-shift strips the power of two
    // out of the divisor (86400 = 128 * 675, 3600 = 16 * 225, 60 = 4 * 15).
    localparam int DayPre   = 7;
    localparam int WeekPre  = 0;
    localparam int HourPre  = 4;
    localparam int MinPre   = 2;
    localparam int DayPost  = 35;
    localparam int WeekPost = 19;
    localparam int HourPost = 21;
    localparam int MinPost  = 14;
    localparam logic [MulBW-1:0] DayMagic  = 26'd50903317;
    localparam logic [MulBW-1:0] WeekMagic = 26'd74899;
    localparam logic [MulBW-1:0] HourMagic = 26'd9321;
    localparam logic [MulBW-1:0] MinMagic  = 26'd1093;

    // 1970-01-01 was a Thursday
    localparam logic [DaysW-1:0] EpochWeekday = 16'd4;
    localparam logic [YearW-1:0] EpochYear    = 12'd1970;
    localparam logic [6:0]       EpochMod100  = 7'd70;
    localparam logic [8:0]       EpochMod400  = 9'd370;
    localparam logic [8:0]       DaysCommon   = 9'd365;
    localparam logic [8:0]       DaysLeap     = 9'd366;
    localparam logic [3:0]       MonthFeb     = 4'd1;
    localparam logic [3:0]       MonthDec     = 4'd11;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DAY,
        S_WEEK,
        S_HOUR,
        S_MIN,
        S_YEAR,
        S_MONTH
    } state_t;

    typedef enum logic [1:0] {
        DIV_DAY,
        DIV_WEEK,
        DIV_HOUR,
        DIV_MIN
    } div_sel_t;

    typedef enum logic [1:0] {
        DP_IDLE,
        DP_QMUL,
        DP_RMUL,
        DP_RSUB
    } div_phase_t;

    typedef struct packed {
        logic             start;
        logic [SecsW-1:0] numer;
        div_sel_t         sel;
    } div_cmd_t;

    typedef struct packed {
        logic             done;
        logic [SecsW-1:0] quot;
        logic [RemW-1:0]  rem;
    } div_res_t;

    function automatic logic [4:0] month_len(input logic [3:0] mi, input logic leap);
        logic [4:0] len;
        begin
            unique case (mi)
                4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
                4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
                MonthFeb:                                  len = leap ? 5'd29 : 5'd28;
                default:                                   len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

[hdl/stc_if.sv]
// ----------------------------------------------------------------------------
// stc_sec_if / stc_date_if
// Valid/ready channels for the seconds count and the calendar date.
// ----------------------------------------------------------------------------
interface stc_sec_if;
    logic        valid;
    logic        ready;
    logic [31:0] seconds_count;

    modport source (output valid, output seconds_count, input ready);
    modport sink   (input valid, input seconds_count, output ready);
endinterface

interface stc_date_if;
    logic        valid;
    logic        ready;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;

    modport source (output valid, output year, output month, output day_of_month,
                    output hour, output minute, output second, output weekday,
                    input ready);
    modport sink   (input valid, input year, input month, input day_of_month,
                    input hour, input minute, input second, input weekday,
                    output ready);
endinterface

[hdl/stc_div.sv]
// ----------------------------------------------------------------------------
// stc_div
// Shared constant divider built on one multiplier: a reciprocal multiply for
// the quotient, a multiply back by the divisor, then a subtract for the
// remainder, in the phases QMUL, RMUL and RSUB; done pulses with the remainder.
// ----------------------------------------------------------------------------
module stc_div
    import stc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_cmd_t cmd,
    output div_res_t res
);

    div_phase_t       phase_reg, phase_next;
    div_sel_t         sel_reg,   sel_next;
    logic             done_reg,  done_next;
    logic [SecsW-1:0] num_reg,   num_next;
    logic [MulPW-1:0] prod_reg,  prod_next;
    logic [DaysW-1:0] quot_reg,  quot_next;
    logic [RemW-1:0]  rem_reg,   rem_next;

    logic [MulAW-1:0] scaled;
    logic [MulBW-1:0] magic;
    logic [DaysW-1:0] quot_est;
    logic [RemW-1:0]  divisor;
    logic [MulAW-1:0] mul_a;
    logic [MulBW-1:0] mul_b;
    logic [MulPW-1:0] mul_p;
    logic [SecsW-1:0] diff;

    // pick the constants of the division in progress
    always_comb
    begin
        unique case (sel_reg)
            DIV_DAY:
            begin
                scaled   = MulAW'(num_reg >> DayPre);
                magic    = DayMagic;
                quot_est = prod_reg[DayPost +: DaysW];
                divisor  = SecsPerDay;
            end
            DIV_WEEK:
            begin
                scaled   = MulAW'(num_reg >> WeekPre);
                magic    = WeekMagic;
                quot_est = prod_reg[WeekPost +: DaysW];
                divisor  = DaysPerWeek;
            end
            DIV_HOUR:
            begin
                scaled   = MulAW'(num_reg >> HourPre);
                magic    = HourMagic;
                quot_est = prod_reg[HourPost +: DaysW];
                divisor  = SecsPerHour;
            end
            default:
            begin
                scaled   = MulAW'(num_reg >> MinPre);
                magic    = MinMagic;
                quot_est = prod_reg[MinPost +: DaysW];
                divisor  = SecsPerMin;
            end
        endcase
    end

    assign mul_a = (phase_reg == DP_QMUL) ? scaled
                                          : {{(MulAW-DaysW){1'b0}}, quot_est};
    assign mul_b = (phase_reg == DP_QMUL) ? magic
                                          : {{(MulBW-RemW){1'b0}}, divisor};
    assign mul_p = {{MulBW{1'b0}}, mul_a} * {{MulAW{1'b0}}, mul_b};
    assign diff  = num_reg - prod_reg[SecsW-1:0];

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            DP_IDLE: if (cmd.start) phase_next = DP_QMUL;
            DP_QMUL: phase_next = DP_RMUL;
            DP_RMUL: phase_next = DP_RSUB;
            DP_RSUB: phase_next = DP_IDLE;
            default: phase_next = DP_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        sel_next  = sel_reg;
        done_next = 1'b0;
        num_next  = num_reg;
        prod_next = prod_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        unique case (phase_reg)
            DP_IDLE:
            begin
                if (cmd.start)
                begin
                    sel_next = cmd.sel;
                    num_next = cmd.numer;
                end
            end
            DP_QMUL:
            begin
                prod_next = mul_p;
            end
            DP_RMUL:
            begin
                quot_next = quot_est;
                prod_next = mul_p;
            end
            DP_RSUB:
            begin
                rem_next  = diff[RemW-1:0];
                done_next = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= DP_IDLE;
            sel_reg   <= DIV_DAY;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            sel_reg   <= sel_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        prod_reg <= prod_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign res.done = done_reg;
    assign res.quot = {{(SecsW-DaysW){1'b0}}, quot_reg};
    assign res.rem  = rem_reg;

endmodule

[hdl/seconds_to_calendar_date.sv]
// ----------------------------------------------------------------------------
// seconds_to_calendar_date
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into the
// Gregorian date, time of day and weekday.
// ----------------------------------------------------------------------------
// One item at a time: a count is taken when ready is high, and ready stays
// low until the conversion is done. One shared multiplier does four
// divisions by constants in turn, each as a reciprocal multiply, a multiply
// back and a subtract: by 86400, day count plus four by 7, time of day by
// 3600, remainder by 60. Then the whole years are walked at one year per
// cycle and the months at one month per cycle. When the result is written
// to the output, ready returns in the same cycle. The result waits in an
// output register; a new count may be taken while it waits, but the next
// result is held back until the earlier one is taken.
module seconds_to_calendar_date
    import stc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    stc_sec_if.sink           seconds,
    stc_date_if.source        date
);

    state_t           state_reg, state_next;
    div_cmd_t         cmd;
    div_res_t         res;

    logic [DaysW-1:0] days_reg,  days_next;
    logic [RemW-1:0]  tod_reg,   tod_next;
    logic [YearW-1:0] year_reg,  year_next;
    logic [6:0]       y100_reg,  y100_next;
    logic [8:0]       y400_reg,  y400_next;
    logic [3:0]       mi_reg,    mi_next;
    logic [2:0]       wd_reg,    wd_next;
    logic [4:0]       hour_reg,  hour_next;
    logic [5:0]       min_reg,   min_next;
    logic [5:0]       sec_reg,   sec_next;

    logic             ovalid_reg, ovalid_next;
    logic [YearW-1:0] oyear_reg;
    logic [3:0]       omonth_reg;
    logic [4:0]       oday_reg;
    logic [4:0]       ohour_reg;
    logic [5:0]       omin_reg;
    logic [5:0]       osec_reg;
    logic [2:0]       owd_reg;

    logic             leap;
    logic [8:0]       ylen;
    logic             year_step;
    logic [4:0]       mlen;
    logic             month_stop;
    logic             slot_free;
    logic             finish;
    logic [DaysW-1:0] week_num;

    stc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res)
    );

    assign leap       = ((year_reg[1:0] == 2'b00) && (y100_reg != '0)) || (y400_reg == '0);
    assign ylen       = leap ? DaysLeap : DaysCommon;
    assign year_step  = days_reg >= {{(DaysW-9){1'b0}}, ylen};
    assign mlen       = month_len(mi_reg, leap);
    assign month_stop = (days_reg < {{(DaysW-5){1'b0}}, mlen}) || (mi_reg == MonthDec);
    assign slot_free  = !ovalid_reg || date.ready;
    assign finish     = (state_reg == S_MONTH) && month_stop && slot_free;
    assign week_num   = res.quot[DaysW-1:0] + EpochWeekday;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (seconds.valid) state_next = S_DAY;
            S_DAY:   if (res.done) state_next = S_WEEK;
            S_WEEK:  if (res.done) state_next = S_HOUR;
            S_HOUR:  if (res.done) state_next = S_MIN;
            S_MIN:   if (res.done) state_next = S_YEAR;
            S_YEAR:  if (!year_step) state_next = S_MONTH;
            S_MONTH: if (month_stop && slot_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // divider commands and handshake
    always_comb
    begin
        seconds.ready = (state_reg == S_IDLE);
        cmd           = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.start = seconds.valid;
                cmd.numer = seconds.seconds_count;
                cmd.sel   = DIV_DAY;
            end
            S_DAY:
            begin
                cmd.start = res.done;
                cmd.numer = {{(SecsW-DaysW){1'b0}}, week_num};
                cmd.sel   = DIV_WEEK;
            end
            S_WEEK:
            begin
                cmd.start = res.done;
                cmd.numer = {{(SecsW-RemW){1'b0}}, tod_reg};
                cmd.sel   = DIV_HOUR;
            end
            S_HOUR:
            begin
                cmd.start = res.done;
                cmd.numer = {{(SecsW-12){1'b0}}, res.rem[11:0]};
                cmd.sel   = DIV_MIN;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        days_next = days_reg;
        tod_next  = tod_reg;
        year_next = year_reg;
        y100_next = y100_reg;
        y400_next = y400_reg;
        mi_next   = mi_reg;
        wd_next   = wd_reg;
        hour_next = hour_reg;
        min_next  = min_reg;
        sec_next  = sec_reg;
        unique case (state_reg)
            S_DAY:
            begin
                if (res.done)
                begin
                    days_next = res.quot[DaysW-1:0];
                    tod_next  = res.rem;
                end
            end
            S_WEEK:
            begin
                if (res.done) wd_next = res.rem[2:0];
            end
            S_HOUR:
            begin
                if (res.done) hour_next = res.quot[4:0];
            end
            S_MIN:
            begin
                if (res.done)
                begin
                    min_next  = res.quot[5:0];
                    sec_next  = res.rem[5:0];
                    year_next = EpochYear;
                    y100_next = EpochMod100;
                    y400_next = EpochMod400;
                    mi_next   = '0;
                end
            end
            S_YEAR:
            begin
                if (year_step)
                begin
                    days_next = days_reg - {{(DaysW-9){1'b0}}, ylen};
                    year_next = year_reg + 1'b1;
                    y100_next = (y100_reg == 7'd99)  ? '0 : y100_reg + 1'b1;
                    y400_next = (y400_reg == 9'd399) ? '0 : y400_reg + 1'b1;
                end
            end
            S_MONTH:
            begin
                if (!month_stop)
                begin
                    days_next = days_reg - {{(DaysW-5){1'b0}}, mlen};
                    mi_next   = mi_reg + 1'b1;
                end
            end
            default:
            begin
                days_next = days_reg;
            end
        endcase
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (date.valid && date.ready) ovalid_next = 1'b0;
        if (finish) ovalid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        days_reg <= days_next;
        tod_reg  <= tod_next;
        year_reg <= year_next;
        y100_reg <= y100_next;
        y400_reg <= y400_next;
        mi_reg   <= mi_next;
        wd_reg   <= wd_next;
        hour_reg <= hour_next;
        min_reg  <= min_next;
        sec_reg  <= sec_next;
        if (finish)
        begin
            oyear_reg  <= year_reg;
            omonth_reg <= mi_reg + 1'b1;
            oday_reg   <= days_reg[4:0] + 1'b1;
            ohour_reg  <= hour_reg;
            omin_reg   <= min_reg;
            osec_reg   <= sec_reg;
            owd_reg    <= wd_reg;
        end
    end

    assign date.valid        = ovalid_reg;
    assign date.year         = oyear_reg;
    assign date.month        = omonth_reg;
    assign date.day_of_month = oday_reg;
    assign date.hour         = ohour_reg;
    assign date.minute       = omin_reg;
    assign date.second       = osec_reg;
    assign date.weekday      = owd_reg;

endmodule

[hdl/stc_check.sv]
// ----------------------------------------------------------------------------
// stc_check
// Port-level checks for the seconds to calendar date converter.
// ----------------------------------------------------------------------------
module stc_check
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [11:0] year,
    input logic [3:0]  month,
    input logic [4:0]  day_of_month,
    input logic [4:0]  hour,
    input logic [5:0]  minute,
    input logic [5:0]  second,
    input logic [2:0]  weekday
);

    // busy right after an item is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready high right after an item was taken");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(year) && $stable(month)
            && $stable(day_of_month) && $stable(hour) && $stable(minute)
            && $stable(second) && $stable(weekday))
        else $error("stalled result changed");

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> year >= 12'd1970 && year <= 12'd2106 && month >= 4'd1
            && month <= 4'd12 && day_of_month >= 5'd1 && weekday <= 3'd6)
        else $error("date field out of range");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59)
        else $error("time field out of range");

endmodule

bind seconds_to_calendar_date stc_check u_stc_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (seconds.valid),
    .in_ready     (seconds.ready),
    .out_valid    (date.valid),
    .out_ready    (date.ready),
    .year         (date.year),
    .month        (date.month),
    .day_of_month (date.day_of_month),
    .hour         (date.hour),
    .minute       (date.minute),
    .second       (date.second),
    .weekday      (date.weekday)
);

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Checks the seconds to calendar date converter: second counts go in over a
// valid/ready channel, and every date that comes out is matched field by
// field against a date computed here by walking years and months from 1970.
// ----------------------------------------------------------------------------
module tb;
    import stc_pkg::*;

    localparam int unsigned StallLimit   = 4000;
    localparam int unsigned DrainCycles  = 300;
    localparam int unsigned HoldOffLen   = 800;
    localparam int unsigned MonthDays[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
    } calendar_t;

    logic clk = 1'b0;
    logic rst_n;

    stc_sec_if  seconds_ch ();
    stc_date_if date_ch ();

    seconds_to_calendar_date dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .seconds (seconds_ch),
        .date    (date_ch)
    );

    always #4 clk = ~clk;

    calendar_t   expected_dates[$];
    bit          idle_on;
    int unsigned hold_cycles;
    int unsigned holdoffs_done;
    int unsigned counts_sent;
    int unsigned dates_checked;
    int unsigned date_errors;
    int unsigned stall_cycles;

    // ------------------------------------------------------------------
    // calendar arithmetic
    // ------------------------------------------------------------------
    function automatic bit is_leap(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
        if (m == 2 && is_leap(y))
            return 29;
        return MonthDays[m-1];
    endfunction

    function automatic calendar_t calendar_of(input logic [31:0] secs);
        int unsigned total, day_cnt, tod, yr, mon, y, m, sum;
        calendar_t   c;
        total   = secs;
        day_cnt = total / 86400;
        tod     = total % 86400;
        yr      = 1970;
        // a leap year with exactly 365 days left holds the year
        while (day_cnt >= (is_leap(yr) ? 366 : 365))
        begin
            day_cnt -= is_leap(yr) ? 366 : 365;
            yr++;
        end
        mon = 1;
        while (mon < 12 && day_cnt >= month_length(yr, mon))
        begin
            day_cnt -= month_length(yr, mon);
            mon++;
        end
        c.year         = yr[11:0];
        c.month        = mon[3:0];
        c.day_of_month = 5'(day_cnt + 1);
        c.hour         = 5'(tod / 3600);
        c.minute       = 6'((tod % 3600) / 60);
        c.second       = 6'(tod % 60);
        // Larsson congruence: Jan and Feb count as months 13, 14 of the prior year
        y = yr;
        m = mon;
        if (m < 3)
        begin
            m += 12;
            y -= 1;
        end
        sum = day_cnt + 2 + 2 * m + (3 * (m + 1)) / 5 + y + y / 4 - y / 100 + y / 400;
        c.weekday = 3'(sum % 7);
        return c;
    endfunction

    function automatic logic [31:0] seconds_at(input int unsigned y, input int unsigned m,
                                               input int unsigned d, input int unsigned hh,
                                               input int unsigned mm, input int unsigned ss);
        longint unsigned days;
        int unsigned     yy, mo;
        days = d - 1;
        for (yy = 1970; yy < y; yy++)
            days += is_leap(yy) ? 366 : 365;
        for (mo = 1; mo < m; mo++)
            days += month_length(y, mo);
        return 32'(days * 86400 + hh * 3600 + mm * 60 + ss);
    endfunction

    // ------------------------------------------------------------------
    // sender: one count per call, valid held high across back-to-back items
    // ------------------------------------------------------------------
    task automatic send_count(input logic [31:0] secs);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 12) : 0;
        if (gap != 0)
        begin
            seconds_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        seconds_ch.valid         <= 1'b1;
        seconds_ch.seconds_count <= secs;
        do
        begin
            @(posedge clk);
        end
        while (!seconds_ch.ready);
        expected_dates.push_back(calendar_of(secs));
        counts_sent++;
    endtask

    // ------------------------------------------------------------------
    // receiver and checker
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            date_errors++;
        end
    endtask

    initial
    begin : date_checker
        int unsigned gap;
        calendar_t   want;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_cycles != 0)
            begin
                gap         = hold_cycles;
                hold_cycles = 0;
                holdoffs_done++;
            end
            else
            begin
                gap = idle_on ? $urandom_range(0, 12) : 0;
            end
            if (gap != 0)
            begin
                date_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            date_ch.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!date_ch.valid);
            dates_checked++;
            if (expected_dates.size() == 0)
            begin
                $error("date %0d-%0d-%0d arrived with no count pending",
                       date_ch.year, date_ch.month, date_ch.day_of_month);
                date_errors++;
            end
            else
            begin
                want = expected_dates.pop_front();
                check_field("year", want.year, date_ch.year);
                check_field("month", want.month, date_ch.month);
                check_field("day_of_month", want.day_of_month, date_ch.day_of_month);
                check_field("hour", want.hour, date_ch.hour);
                check_field("minute", want.minute, date_ch.minute);
                check_field("second", want.second, date_ch.second);
                check_field("weekday", want.weekday, date_ch.weekday);
            end
        end
    end

    // drop the run if neither channel moves for too long
    always @(posedge clk)
    begin
        if ((seconds_ch.valid && seconds_ch.ready) || (date_ch.valid && date_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == StallLimit)
        begin
            $display("timeout: no item moved for %0d cycles", StallLimit);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_range_edges();
        send_count(32'd0);
        send_count(32'd1);
        send_count(32'd86399);
        send_count(32'd86400);
        send_count(32'h7FFF_FFFF);
        send_count(32'h8000_0000);
        send_count(seconds_at(2106, 2, 7, 0, 0, 0));
        send_count(32'hFFFF_FFFF);
    endtask

    task automatic test_leap_rules();
        send_count(seconds_at(1971, 12, 31, 23, 59, 59));
        send_count(seconds_at(1972, 2, 28, 23, 59, 59));
        send_count(seconds_at(1972, 2, 29, 12, 30, 45));
        send_count(seconds_at(1972, 3, 1, 0, 0, 0));
        send_count(seconds_at(1972, 12, 31, 23, 59, 59));
        send_count(seconds_at(1973, 1, 1, 0, 0, 0));
        send_count(seconds_at(2000, 2, 29, 6, 0, 0));
        send_count(seconds_at(2000, 12, 31, 23, 59, 59));
        send_count(seconds_at(2096, 12, 31, 0, 0, 0));
        send_count(seconds_at(2100, 2, 28, 23, 59, 59));
        send_count(seconds_at(2100, 3, 1, 0, 0, 0));
        send_count(seconds_at(2023, 4, 30, 23, 59, 59));
        send_count(seconds_at(2023, 11, 30, 0, 0, 0));
    endtask

    task automatic test_random_counts(input int unsigned n);
        logic [31:0] secs;
        repeat (n)
        begin
            secs = $urandom;
            // weight the top of the range toward the 2106 rollover
            if ($urandom_range(0, 7) == 0)
                secs[31:28] = 4'hF;
            send_count(secs);
        end
    endtask

    task automatic test_month_boundaries(input int unsigned n);
        int unsigned y, m, d, hh, mm, ss;
        repeat (n)
        begin
            y = $urandom_range(1970, 2105);
            m = $urandom_range(1, 12);
            case ($urandom_range(0, 2))
                0:       d = 1;
                1:       d = month_length(y, m);
                default: d = $urandom_range(1, month_length(y, m));
            endcase
            case ($urandom_range(0, 2))
                0:       begin hh = 0;  mm = 0;  ss = 0;  end
                1:       begin hh = 23; mm = 59; ss = 59; end
                default:
                begin
                    hh = $urandom_range(0, 23);
                    mm = $urandom_range(0, 59);
                    ss = $urandom_range(0, 59);
                end
            endcase
            send_count(seconds_at(y, m, d, hh, mm, ss));
        end
    endtask

    task automatic test_back_to_back(input int unsigned n);
        idle_on = 1'b0;
        test_random_counts(n);
        idle_on = 1'b1;
    endtask

    task automatic test_output_stall();
        idle_on     = 1'b0;
        hold_cycles = HoldOffLen;
        test_random_counts(20);
        idle_on     = 1'b1;
    endtask

    initial
    begin
        rst_n                    = 1'b0;
        seconds_ch.valid         = 1'b0;
        seconds_ch.seconds_count = '0;
        date_ch.ready            = 1'b0;
        idle_on                  = 1'b1;
        hold_cycles              = 0;
        holdoffs_done            = 0;
        counts_sent              = 0;
        dates_checked            = 0;
        date_errors              = 0;
        stall_cycles             = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_range_edges();
        test_leap_rules();
        test_random_counts(500);
        test_output_stall();
        test_month_boundaries(400);
        test_back_to_back(250);

        seconds_ch.valid <= 1'b0;
        while (expected_dates.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        $display("%0d second counts converted, %0d dates compared field by field",
                 counts_sent, dates_checked);
        $display("years 1970-2106 with leap and century rules, %0d long output stall(s)",
                 holdoffs_done);
        if (date_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
hdl/stc_pkg.sv
hdl/stc_if.sv
hdl/stc_div.sv
hdl/seconds_to_calendar_date.sv
hdl/stc_check.sv
tb/sv/tb.sv
